### sv/arc_pkg.sv
// shared types and constants for the arp responder with address cache
// no dependencies; imported by every module of the block
package arc_pkg;

    localparam int ARC_CACHE_ENTRIES = 16;

    localparam logic [1:0] CMD_RX      = 2'd0;
    localparam logic [1:0] CMD_LOOKUP  = 2'd1;
    localparam logic [1:0] CMD_REQUEST = 2'd2;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_REPLY   = 2'd1;
    localparam logic [1:0] KIND_REQUEST = 2'd2;
    localparam logic [1:0] KIND_LOOKUP  = 2'd3;

    localparam logic [1:0] OPC_NONE    = 2'd0;
    localparam logic [1:0] OPC_REQUEST = 2'd1;
    localparam logic [1:0] OPC_REPLY   = 2'd2;

    localparam logic [15:0] HTYPE_ETHERNET = 16'h0001;
    localparam logic [15:0] PTYPE_IPV4     = 16'h0800;
    localparam logic [15:0] RX_OP_REQUEST  = 16'h0001;
    localparam logic [10:0] MIN_ARP_LENGTH = 11'd28;

    localparam logic [47:0] MAC_BROADCAST = 48'hFFFF_FFFF_FFFF;

    localparam logic CFG_OWN_MAC = 1'b0;
    localparam logic CFG_OWN_IP  = 1'b1;

    typedef struct packed {
        logic [1:0]  command;
        logic [10:0] packet_length;
        logic [15:0] hardware_type;
        logic [15:0] protocol_type;
        logic [15:0] operation;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [31:0] target_ip;
    } t_arp_req;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic        lookup_hit;
        logic [47:0] found_mac;
        logic [47:0] frame_dest_mac;
        logic [1:0]  arp_opcode;
        logic [47:0] arp_target_mac;
        logic [31:0] arp_target_ip;
    } t_arp_res;

    // search token walking down the cell row
    typedef struct packed {
        logic        valid;
        logic [31:0] key;
        logic        hit;
        logic        free_seen;
        logic [47:0] hit_mac;
    } t_tok;

    // write broadcast to all cells once the token has left the row
    typedef struct packed {
        logic        merge;
        logic        add;
        logic [47:0] mac;
        logic [31:0] ip;
    } t_commit;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

### sv/arc_cell.sv
// one cache entry of the arp cache row: compares the passing token and
// applies the commit broadcast; depends on arc_pkg
module arc_cell import arc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_tok    i_tok,
    input  t_commit i_commit,
    output t_tok    o_tok
);

    logic [31:0] r_ip;
    logic [47:0] r_mac;
    logic        r_mark_hit;
    logic        r_mark_free;
    t_tok        r_tok;
    logic        match;
    logic        is_free;
    logic        first_hit;
    logic        first_free;

    // ip zero is a free slot and never matches
    assign match      = i_tok.valid && (i_tok.key != 32'd0) && (r_ip == i_tok.key);
    assign is_free    = i_tok.valid && (r_ip == 32'd0);
    assign first_hit  = match && !i_tok.hit;
    assign first_free = is_free && !i_tok.free_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ip        <= 32'd0;
            r_mac       <= 48'd0;
            r_mark_hit  <= 1'b0;
            r_mark_free <= 1'b0;
            r_tok       <= '0;
        end else begin
            r_tok.valid     <= i_tok.valid;
            r_tok.key       <= i_tok.key;
            r_tok.hit       <= i_tok.hit | match;
            r_tok.free_seen <= i_tok.free_seen | is_free;
            r_tok.hit_mac   <= first_hit ? r_mac : i_tok.hit_mac;
            if (i_tok.valid) begin
                r_mark_hit  <= first_hit;
                r_mark_free <= first_free;
            end
            if (i_commit.add && r_mark_free) begin
                r_ip <= i_commit.ip;
            end
            if ((i_commit.merge && r_mark_hit) || (i_commit.add && r_mark_free)) begin
                r_mac <= i_commit.mac;
            end
        end
    end

    assign o_tok = r_tok;

endmodule

### sv/arp_responder_cache.sv
// top level of the arp responder with address cache: request control and
// the row of cache cells; depends on arc_pkg and arc_cell
//
// One request is handled at a time. A received packet that passes the header
// checks, and a lookup, send a search token down a row of CACHE_ENTRIES cells,
// one cell per cycle; the cache update is applied in the cycle the token
// leaves the row, and the result is registered in that cycle as well.
// Send-request commands, dropped packets and unknown commands skip the row:
// their result is registered as they are accepted. The next request is taken
// once the result has moved into the output register, which may still be
// waiting on a stall. The cache is empty right after reset; configuration
// writes are always ready.
module arp_responder_cache import arc_pkg::*; #(
    parameter int CACHE_ENTRIES = ARC_CACHE_ENTRIES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_arp_req    i_in_data,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output t_arp_res    o_out_data,
    input  logic        i_out_stall,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_index,
    input  logic [47:0] i_cfg_data,
    output logic        o_cfg_ready
);

    t_state      r_state, n_state;
    t_arp_req    r_req;
    t_arp_res    r_res, n_res;
    t_arp_res    r_out;
    logic        r_out_valid, n_out_valid;
    logic        out_load;
    logic [47:0] r_own_mac;
    logic [31:0] r_own_ip;
    logic        accept;
    logic        hdr_ok;
    t_commit     commit;
    t_tok        tok_in;
    t_tok        tok [CACHE_ENTRIES+1];

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign accept      = i_in_valid && (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign hdr_ok = (i_in_data.packet_length >= MIN_ARP_LENGTH)
                 && (i_in_data.hardware_type == HTYPE_ETHERNET)
                 && (i_in_data.protocol_type == PTYPE_IPV4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_mac <= 48'd0;
            r_own_ip  <= 32'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OWN_MAC: r_own_mac <= i_cfg_data;
                CFG_OWN_IP:  r_own_ip  <= i_cfg_data[31:0];
                default:     r_own_ip  <= r_own_ip;
            endcase
        end
    end

    // token entering the row
    always_comb begin
        tok_in.valid     = accept && ((i_in_data.command == CMD_LOOKUP)
                        || ((i_in_data.command == CMD_RX) && hdr_ok));
        tok_in.key       = (i_in_data.command == CMD_LOOKUP) ? i_in_data.target_ip
                                                              : i_in_data.sender_ip;
        tok_in.hit       = 1'b0;
        tok_in.free_seen = 1'b0;
        tok_in.hit_mac   = 48'd0;
    end

    assign tok[0] = tok_in;

    for (genvar g = 0; g < CACHE_ENTRIES; g++) begin : g_cell
        arc_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_tok    (tok[g]),
            .i_commit (commit),
            .o_tok    (tok[g+1])
        );
    end

    always_comb begin
        n_state  = r_state;
        n_res    = r_res;
        out_load = 1'b0;
        commit   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_res = '0;
                    if (i_in_data.command == CMD_REQUEST) begin
                        n_res.result_kind    = KIND_REQUEST;
                        n_res.frame_dest_mac = MAC_BROADCAST;
                        n_res.arp_opcode     = OPC_REQUEST;
                        n_res.arp_target_ip  = i_in_data.target_ip;
                    end
                    n_state = tok_in.valid ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                if (tok[CACHE_ENTRIES].valid) begin
                    n_res = '0;
                    if (r_req.command == CMD_LOOKUP) begin
                        n_res.result_kind = KIND_LOOKUP;
                        n_res.lookup_hit  = tok[CACHE_ENTRIES].hit;
                        n_res.found_mac   = tok[CACHE_ENTRIES].hit_mac;
                    end else begin
                        commit.mac   = r_req.sender_mac;
                        commit.ip    = r_req.sender_ip;
                        commit.merge = tok[CACHE_ENTRIES].hit;
                        commit.add   = (r_req.target_ip == r_own_ip)
                                    && !tok[CACHE_ENTRIES].hit
                                    && (r_req.sender_ip != 32'd0);
                        if ((r_req.target_ip == r_own_ip)
                                && (r_req.operation == RX_OP_REQUEST)) begin
                            n_res.result_kind    = KIND_REPLY;
                            n_res.frame_dest_mac = r_req.sender_mac;
                            n_res.arp_opcode     = OPC_REPLY;
                            n_res.arp_target_mac = r_req.sender_mac;
                            n_res.arp_target_ip  = r_req.sender_ip;
                        end
                    end
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (accept) begin
            r_req <= i_in_data;
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

endmodule

### sv/arc_checker.sv
// port-level checks for arp_responder_cache, bound to the top level
// depends on arc_pkg
module arc_checker import arc_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_stall,
    input logic     o_out_valid,
    input t_arp_res o_out_data,
    input logic     i_out_stall
);

    // one request at a time: the input is stalled right after every accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted back to back");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    a_none_is_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.result_kind == KIND_NONE))
        |-> ((o_out_data.arp_opcode == OPC_NONE) && !o_out_data.lookup_hit
             && (o_out_data.frame_dest_mac == 48'd0)))
        else $error("empty result carries frame or lookup data");

    a_hit_only_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.lookup_hit) |-> (o_out_data.result_kind == KIND_LOOKUP))
        else $error("lookup hit outside lookup answer");

    a_request_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.result_kind == KIND_REQUEST))
        |-> ((o_out_data.frame_dest_mac == MAC_BROADCAST)
             && (o_out_data.arp_opcode == OPC_REQUEST)
             && (o_out_data.arp_target_mac == 48'd0)))
        else $error("malformed request frame");

endmodule

bind arp_responder_cache arc_checker u_arc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);

### dv/arp_responder_cache_test.sv
// self-checking testbench for arp_responder_cache: directed and random requests
// checked against an in-bench model of the arp cache; depends on arc_pkg and the rtl
module arp_responder_cache_test;
    import arc_pkg::*;

    localparam logic [1:0]  CMD_UNKNOWN  = 2'd3;
    localparam logic [15:0] RX_OP_REPLY  = 16'h0002;
    localparam int          IP_POOL_SIZE = 24;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_in_valid = 1'b0;
    t_arp_req i_in_data = '0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_arp_res o_out_data;
    logic     i_out_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [47:0] i_cfg_data = '0;
    logic        o_cfg_ready;

    // in-bench copy of the cache and registers
    logic [47:0] cache_mac [ARC_CACHE_ENTRIES] = '{default: '0};
    logic [31:0] cache_ip [ARC_CACHE_ENTRIES] = '{default: '0};
    logic [47:0] own_mac_reg = '0;
    logic [31:0] own_ip_reg = '0;
    logic [31:0] ip_pool [IP_POOL_SIZE];

    t_arp_res expected_res_q[$];
    int n_errors = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int n_sent = 0, n_replies = 0, n_req_frames = 0, n_lookups = 0, n_hits = 0;
    int n_dropped = 0, n_added = 0, n_add_refused = 0;

    arp_responder_cache uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    always #5 i_clk = ~i_clk;

    function automatic int find_slot(input logic [31:0] ip);
        for (int i = 0; i < ARC_CACHE_ENTRIES; i++) begin
            if (cache_ip[i] == ip) return i;
        end
        return -1;
    endfunction

    // updates the cache copy and returns the result the request should produce
    function automatic t_arp_res predict_arp(input t_arp_req r);
        t_arp_res res;
        int hit;
        int slot;
        res = '0;
        hit = -1;
        case (r.command)
            CMD_RX: begin
                if (r.packet_length < MIN_ARP_LENGTH || r.hardware_type != HTYPE_ETHERNET
                        || r.protocol_type != PTYPE_IPV4) begin
                    n_dropped++;
                end else begin
                    // ip zero marks a free slot and never matches
                    if (r.sender_ip != '0) hit = find_slot(r.sender_ip);
                    if (hit >= 0) cache_mac[hit] = r.sender_mac;
                    if (r.target_ip == own_ip_reg) begin
                        if (hit < 0 && r.sender_ip != '0) begin
                            slot = find_slot('0);
                            if (slot >= 0) begin
                                cache_mac[slot] = r.sender_mac;
                                cache_ip[slot]  = r.sender_ip;
                                n_added++;
                            end else begin
                                n_add_refused++;
                            end
                        end
                        if (r.operation == RX_OP_REQUEST) begin
                            res.result_kind    = KIND_REPLY;
                            res.frame_dest_mac = r.sender_mac;
                            res.arp_opcode     = OPC_REPLY;
                            res.arp_target_mac = r.sender_mac;
                            res.arp_target_ip  = r.sender_ip;
                            n_replies++;
                        end
                    end
                end
            end
            CMD_LOOKUP: begin
                res.result_kind = KIND_LOOKUP;
                n_lookups++;
                if (r.target_ip != '0) hit = find_slot(r.target_ip);
                if (hit >= 0) begin
                    res.lookup_hit = 1'b1;
                    res.found_mac  = cache_mac[hit];
                    n_hits++;
                end
            end
            CMD_REQUEST: begin
                res.result_kind    = KIND_REQUEST;
                res.frame_dest_mac = MAC_BROADCAST;
                res.arp_opcode     = OPC_REQUEST;
                res.arp_target_ip  = r.target_ip;
                n_req_frames++;
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_arp_req make_rx(input logic [10:0] plen, input logic [15:0] htype,
            input logic [15:0] ptype, input logic [15:0] op, input logic [47:0] smac,
            input logic [31:0] sip, input logic [31:0] tip);
        t_arp_req r;
        r.command       = CMD_RX;
        r.packet_length = plen;
        r.hardware_type = htype;
        r.protocol_type = ptype;
        r.operation     = op;
        r.sender_mac    = smac;
        r.sender_ip     = sip;
        r.target_ip     = tip;
        return r;
    endfunction

    // non-rx commands: unused fields get random content
    function automatic t_arp_req make_cmd(input logic [1:0] cmd, input logic [31:0] tip);
        t_arp_req r;
        r = make_rx(11'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    {16'($urandom), $urandom}, $urandom, tip);
        r.command = cmd;
        return r;
    endfunction

    function automatic logic [31:0] pick_ip();
        int roll;
        roll = $urandom_range(99);
        if (roll < 75) return ip_pool[$urandom_range(IP_POOL_SIZE - 1)];
        if (roll < 90) return $urandom;
        return '0;
    endfunction

    function automatic t_arp_req random_req();
        t_arp_req r;
        int roll;
        int pick;
        roll = $urandom_range(99);
        r = make_rx(11'($urandom_range(2047, MIN_ARP_LENGTH)), HTYPE_ETHERNET, PTYPE_IPV4,
                    ($urandom_range(9) < 6) ? RX_OP_REQUEST : RX_OP_REPLY,
                    {16'($urandom), $urandom}, pick_ip(),
                    ($urandom_range(9) < 6) ? own_ip_reg : pick_ip());
        if (roll < 12) begin
            // noise
            r = make_rx(11'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        {16'($urandom), $urandom}, $urandom, $urandom);
            r.command = 2'($urandom);
        end else if (roll < 22) begin
            // well-formed apart from one checked header field, now and then with a random operation
            case ($urandom_range(2))
                0: r.packet_length = 11'($urandom_range(MIN_ARP_LENGTH - 1));
                1: r.hardware_type = HTYPE_ETHERNET ^ 16'($urandom_range(65535, 1));
                default: r.protocol_type = PTYPE_IPV4 ^ 16'($urandom_range(65535, 1));
            endcase
            if ($urandom_range(3) == 0) r.operation = 16'($urandom);
        end else begin
            pick = $urandom_range(99);
            if (pick >= 95)      r = make_cmd(CMD_UNKNOWN, $urandom);
            else if (pick >= 80) r = make_cmd(CMD_REQUEST, $urandom);
            else if (pick >= 55) r = make_cmd(CMD_LOOKUP, pick_ip());
            else if ($urandom_range(19) == 0) r.operation = 16'($urandom);
        end
        return r;
    endfunction

    task automatic send_arp(input t_arp_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        do @(posedge i_clk); while (o_in_stall);
        expected_res_q.push_back(predict_arp(r));
        n_sent++;
    endtask

    // hold off until every result is back and the block has gone quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_res_q.size() != 0);
        repeat (ARC_CACHE_ENTRIES + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [47:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_OWN_MAC) own_mac_reg = value;
        else                    own_ip_reg  = value[31:0];
        @(posedge i_clk);
    endtask

    task automatic field_mismatch(input string name, input logic [63:0] want_v,
            input logic [63:0] got_v);
        $display("%0t mismatch %s: expected %h actual %h", $time, name, want_v, got_v);
        n_errors++;
    endtask

    task automatic check_result(input t_arp_res got);
        t_arp_res want;
        if (expected_res_q.size() == 0) begin
            $display("%0t unexpected result: expected none actual %h", $time, got);
            n_errors++;
        end else begin
            want = expected_res_q.pop_front();
            if (got.result_kind !== want.result_kind)
                field_mismatch("result_kind", want.result_kind, got.result_kind);
            if (got.lookup_hit !== want.lookup_hit)
                field_mismatch("lookup_hit", want.lookup_hit, got.lookup_hit);
            if (got.found_mac !== want.found_mac)
                field_mismatch("found_mac", want.found_mac, got.found_mac);
            if (got.frame_dest_mac !== want.frame_dest_mac)
                field_mismatch("frame_dest_mac", want.frame_dest_mac, got.frame_dest_mac);
            if (got.arp_opcode !== want.arp_opcode)
                field_mismatch("arp_opcode", want.arp_opcode, got.arp_opcode);
            if (got.arp_target_mac !== want.arp_target_mac)
                field_mismatch("arp_target_mac", want.arp_target_mac, got.arp_target_mac);
            if (got.arp_target_ip !== want.arp_target_ip)
                field_mismatch("arp_target_ip", want.arp_target_ip, got.arp_target_ip);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) check_result(o_out_data);
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // reset register values, ip zero on an empty cache, unknown command, request frame
    task automatic test_defaults();
        t_arp_req r;
        send_arp(make_cmd(CMD_LOOKUP, '0));
        send_arp(make_rx(MIN_ARP_LENGTH, HTYPE_ETHERNET, PTYPE_IPV4, RX_OP_REQUEST,
                         '0, '0, '0));
        r = '1;
        r.command = CMD_UNKNOWN;
        send_arp(r);
        send_arp(make_cmd(CMD_REQUEST, '0));
        settle();
    endtask

    // header checks, add, refresh, targeted and untargeted packets, lookups
    task automatic test_rx_rules();
        write_reg(CFG_OWN_MAC, '1);
        write_reg(CFG_OWN_IP, 48'hFFFF_FFFF);
        send_arp(make_rx(MIN_ARP_LENGTH - 1, HTYPE_ETHERNET, PTYPE_IPV4, RX_OP_REQUEST,
                         48'h0A0B_0C0D_0E0F, 32'd5, '1));
        send_arp(make_rx(11'd2047, '1, PTYPE_IPV4, RX_OP_REQUEST, 48'h1, 32'd5, '1));
        send_arp(make_rx(11'd2047, HTYPE_ETHERNET, '0, RX_OP_REQUEST, 48'h1, 32'd5, '1));
        send_arp(make_rx(11'd2047, HTYPE_ETHERNET, PTYPE_IPV4, RX_OP_REQUEST, '1, '1, '1));
        send_arp(make_rx(MIN_ARP_LENGTH, HTYPE_ETHERNET, PTYPE_IPV4, RX_OP_REPLY,
                         '0, 32'd1, '1));
        send_arp(make_rx(11'd100, HTYPE_ETHERNET, PTYPE_IPV4, '1,
                         48'h5555_AAAA_5555, 32'd2, '1));
        // not aimed at us: refresh only, never an add
        send_arp(make_rx(11'd60, HTYPE_ETHERNET, PTYPE_IPV4, RX_OP_REQUEST,
                         48'h1234_5678_9ABC, 32'd1, '0));
        send_arp(make_rx(11'd60, HTYPE_ETHERNET, PTYPE_IPV4, RX_OP_REQUEST,
                         48'hAAAA_5555_AAAA, 32'd7, '0));
        send_arp(make_cmd(CMD_LOOKUP, '1));
        send_arp(make_cmd(CMD_LOOKUP, 32'd1));
        send_arp(make_cmd(CMD_LOOKUP, 32'd7));
        send_arp(make_cmd(CMD_LOOKUP, '0));
        send_arp(make_cmd(CMD_REQUEST, '1));
        // known sender aimed at us: reply with the entry refreshed in place
        send_arp(make_rx(MIN_ARP_LENGTH, HTYPE_ETHERNET, PTYPE_IPV4, RX_OP_REQUEST,
                         48'h0000_FFFF_0000, 32'd1, '1));
        settle();
    endtask

    // fill every free slot, then one more add that must be refused
    task automatic test_cache_full();
        for (int k = 0; k < ARC_CACHE_ENTRIES - 2; k++) begin
            send_arp(make_rx(MIN_ARP_LENGTH, HTYPE_ETHERNET, PTYPE_IPV4, RX_OP_REPLY,
                             {16'($urandom), $urandom}, ip_pool[k], own_ip_reg));
        end
        send_arp(make_cmd(CMD_LOOKUP, ip_pool[ARC_CACHE_ENTRIES - 3]));
        send_arp(make_cmd(CMD_LOOKUP, ip_pool[0]));
        settle();
    endtask

    task automatic test_random(input int tx_idle, input int rx_idle, input int count,
            input logic [47:0] mac, input logic [31:0] ip);
        write_reg(CFG_OWN_MAC, mac);
        write_reg(CFG_OWN_IP, {16'h0, ip});
        send_idle_pct = tx_idle;
        recv_idle_pct = rx_idle;
        for (int k = 0; k < count; k++) begin
            // now and then let the pipeline drain completely before the next request
            if (k % 97 == 96) settle();
            send_arp(random_req());
        end
        settle();
    endtask

    initial begin
        for (int k = 0; k < IP_POOL_SIZE; k++) begin
            ip_pool[k] = ($urandom & 32'hFFFF_FF00) | (k + 8);
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults();
        test_rx_rules();
        test_cache_full();
        test_random(33, 74, 430, {16'($urandom), $urandom}, ip_pool[3]);
        test_random(74, 33, 430, '0, '0);
        test_random(0, 0, 440, '1, '1);
        $display("covered %0d requests: %0d replies, %0d request frames, %0d lookups (%0d hits)",
                 n_sent, n_replies, n_req_frames, n_lookups, n_hits);
        $display("%0d packets dropped on header checks, %0d cache adds, %0d adds refused",
                 n_dropped, n_added, n_add_refused);
        if (n_errors == 0) begin
            $display("[arp_responder_cache] OK");
        end else begin
            $display("[arp_responder_cache] ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[arp_responder_cache] ERROR");
        $finish;
    end

endmodule
